>>> rtl/pgn_pkg.sv
// Shared constants and helpers for the 2D gradient noise pipeline.
package pgn_pkg;

    // corner hash
    localparam logic [31:0] HASH_MUL_X = 32'd73856093;
    localparam logic [31:0] HASH_MUL_Z = 32'd19349663;
    localparam logic [31:0] HASH_MUL_C = 32'd60493;
    localparam int          HASH_SHIFT = 13;
    localparam int          HASH_W     = 16;

    // sin(pi/2 * t) odd polynomial, Q30
    localparam int ACC_W = 32;
    localparam logic signed [ACC_W-1:0] SIN_C1 = 32'sd1686629713;
    localparam logic signed [ACC_W-1:0] SIN_C3 = -32'sd693598668;
    localparam logic signed [ACC_W-1:0] SIN_C5 = 32'sd85569306;
    localparam logic signed [ACC_W-1:0] SIN_C7 = -32'sd5026995;
    localparam logic signed [ACC_W-1:0] SIN_C9 = 32'sd172272;

    localparam int T_W    = 31;     // phase in Q30, up to 1.0
    localparam int GRAD_W = 17;     // gradient component, Q15 in [-1, 1]
    localparam int DOT_W  = 34;     // corner dot product, Q30

    // Q30 product of signed accumulator and unsigned phase term, floored
    function automatic logic signed [ACC_W-1:0] mul_q30(
        input logic signed [ACC_W-1:0] a,
        input logic [T_W-1:0]          b
    );
        logic signed [ACC_W+T_W:0] p;
        p = a * $signed({1'b0, b});
        return ACC_W'(p >>> 30);
    endfunction

endpackage

>>> rtl/pgn_corner.sv
// One cell corner: seed hash, gradient from polynomial sine, dot with offset.
module pgn_corner #(
    parameter int FRAC_BITS  = 16,
    parameter int ANGLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [31:0]                      seed,
    input  logic [31:0]                      cx,
    input  logic [31:0]                      cz,
    input  logic signed [FRAC_BITS:0]        dx,
    input  logic signed [FRAC_BITS:0]        dz,
    output logic signed [pgn_pkg::DOT_W-1:0] dot
);

    localparam int D_W    = FRAC_BITS + 1;
    localparam int P_W    = ANGLE_BITS - 1;
    localparam int PROD_W = pgn_pkg::GRAD_W + D_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DLY    = 12;
    localparam int SQ_W   = 2 * pgn_pkg::T_W;

    logic [31:0] hx_reg, hz_reg, h0_reg, sq_reg, cu_reg, m_reg;
    logic signed [D_W-1:0] dx_reg [DLY];
    logic signed [D_W-1:0] dz_reg [DLY];

    logic [pgn_pkg::T_W-1:0]          t_reg   [2][6];
    logic [pgn_pkg::T_W-1:0]          t2_reg  [2][4];
    logic                             neg_reg [2][7];
    logic signed [pgn_pkg::ACC_W-1:0] acc_reg [2][4];
    logic signed [pgn_pkg::ACC_W-1:0] s_reg   [2];
    logic signed [pgn_pkg::GRAD_W-1:0] g_reg  [2];
    logic signed [PROD_W-1:0]         px_reg, pz_reg;
    logic signed [pgn_pkg::DOT_W-1:0] dot_reg;

    logic [31:0]                      h0_c, hm_c;
    logic [ANGLE_BITS-1:0]            ang_c [2];
    logic [pgn_pkg::T_W-1:0]          t_c   [2];
    logic                             neg_c [2];
    logic signed [pgn_pkg::GRAD_W-1:0] g_c  [2];
    logic signed [SUM_W-1:0]          sum_c;
    logic signed [pgn_pkg::DOT_W-1:0] dot_c;

    assign h0_c = hx_reg ^ hz_reg ^ seed;
    assign hm_c = m_reg ^ (m_reg >> pgn_pkg::HASH_SHIFT);

    // lane 0 is sine, lane 1 cosine (angle plus a quarter turn)
    always_comb
    begin
        logic [P_W-1:0]                phase;
        logic signed [pgn_pkg::ACC_W-1:0] r;
        ang_c[0] = hm_c[pgn_pkg::HASH_W-1 -: ANGLE_BITS];
        ang_c[1] = ang_c[0] + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
        for (int l = 0; l < 2; l++)
        begin
            if (ang_c[l][ANGLE_BITS-2])
                phase = P_W'(1 << (ANGLE_BITS - 2)) - P_W'(ang_c[l][ANGLE_BITS-3:0]);
            else
                phase = P_W'(ang_c[l][ANGLE_BITS-3:0]);
            t_c[l]   = {phase, (32 - ANGLE_BITS)'(0)};
            neg_c[l] = ang_c[l][ANGLE_BITS-1];
            r = (s_reg[l] + $signed(pgn_pkg::ACC_W'(1 << 14))) >>> 15;
            if (r < 0)
                r = '0;
            else if (r > pgn_pkg::ACC_W'(32768))
                r = pgn_pkg::ACC_W'(32768);
            g_c[l] = neg_reg[l][6] ? -pgn_pkg::GRAD_W'(r) : pgn_pkg::GRAD_W'(r);
        end
    end

    assign sum_c = SUM_W'(px_reg) + SUM_W'(pz_reg);

    generate
        if (FRAC_BITS >= 15)
        begin : g_shr
            assign dot_c = pgn_pkg::DOT_W'(sum_c >>> (FRAC_BITS - 15));
        end
        else
        begin : g_shl
            assign dot_c = pgn_pkg::DOT_W'(sum_c) <<< (15 - FRAC_BITS);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // hash
            hx_reg <= cx * pgn_pkg::HASH_MUL_X;
            hz_reg <= cz * pgn_pkg::HASH_MUL_Z;
            h0_reg <= h0_c;
            sq_reg <= h0_c * h0_c;
            cu_reg <= sq_reg * h0_reg;
            m_reg  <= cu_reg * pgn_pkg::HASH_MUL_C;

            dx_reg[0] <= dx;
            dz_reg[0] <= dz;
            for (int k = 1; k < DLY; k++)
            begin
                dx_reg[k] <= dx_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
            end

            // Horner steps, one multiply per stage
            for (int l = 0; l < 2; l++)
            begin
                t_reg[l][0]   <= t_c[l];
                neg_reg[l][0] <= neg_c[l];
                for (int k = 1; k < 6; k++)
                    t_reg[l][k] <= t_reg[l][k-1];
                for (int k = 1; k < 7; k++)
                    neg_reg[l][k] <= neg_reg[l][k-1];
                t2_reg[l][0] <= pgn_pkg::T_W'((SQ_W'(t_reg[l][0]) * SQ_W'(t_reg[l][0])) >> 30);
                for (int k = 1; k < 4; k++)
                    t2_reg[l][k] <= t2_reg[l][k-1];
                acc_reg[l][0] <= pgn_pkg::SIN_C7
                                 + pgn_pkg::mul_q30(pgn_pkg::SIN_C9, t2_reg[l][0]);
                acc_reg[l][1] <= pgn_pkg::SIN_C5
                                 + pgn_pkg::mul_q30(acc_reg[l][0], t2_reg[l][1]);
                acc_reg[l][2] <= pgn_pkg::SIN_C3
                                 + pgn_pkg::mul_q30(acc_reg[l][1], t2_reg[l][2]);
                acc_reg[l][3] <= pgn_pkg::SIN_C1
                                 + pgn_pkg::mul_q30(acc_reg[l][2], t2_reg[l][3]);
                s_reg[l] <= pgn_pkg::mul_q30(acc_reg[l][3], t_reg[l][5]);
                g_reg[l] <= g_c[l];
            end

            px_reg  <= g_reg[1] * dx_reg[DLY-1];
            pz_reg  <= g_reg[0] * dz_reg[DLY-1];
            dot_reg <= dot_c;
        end
    end

    assign dot = dot_reg;

endmodule

>>> rtl/perlin_gradient_noise_2d.sv
// Top level: 2D gradient noise, one Q16.16 point in, one Q1.15 value out per beat.
// Pipeline of 1 split stage, 14 corner stages and 7 blend stages from input beat to output beat.
// Throughput: one beat per cycle; every stage advances together whenever the
//   output register is empty or being taken.
// Reset: rst_n clears all valid bits and the seed to zero; data stages are not reset.
module perlin_gradient_noise_2d #(
    parameter int FRAC_BITS     = 16,
    parameter int ANGLE_BITS    = 16,
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // x_coord [31:0], z_coord [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // noise_value [15:0]
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data  // noise_seed
);

    localparam int D_W     = FRAC_BITS + 1;
    localparam int LAT     = 22;
    localparam int CORNER_OUT = 15;     // first blend stage, fed by the corner outputs
    localparam int FT_W    = 28;        // fade input, Q28
    localparam int A6_W    = 34;
    localparam int Q_W     = 34;
    localparam int W_W     = 29;        // fade weight in [0, 2^28]
    localparam int W_DLY   = 10;
    localparam int DIF_W   = pgn_pkg::DOT_W + 1;
    localparam int R_W     = pgn_pkg::DOT_W + 2;
    localparam int RND_SH  = 30 - OUT_FRAC_BITS;
    localparam int SQF_W   = 2 * FT_W;            // full fade square
    localparam int QP_W    = FT_W + 1 + A6_W;     // full t * (6t - 15)
    localparam int WP_W    = FT_W + 1 + Q_W;      // full t^3 * q
    localparam int BP_W    = W_W + 1 + DIF_W;     // full weight * difference

    // ---------------------------------------------------------------
    // Global advance: the whole pipe moves unless the output is stuck.
    // ---------------------------------------------------------------
    logic adv;
    logic vld_reg [LAT];
    logic [31:0] noise_seed_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg <= '0;
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                noise_seed_reg <= cfg_wr_data;
            if (adv)
            begin
                vld_reg[0] <= s_tvalid;
                for (int k = 1; k < LAT; k++)
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: integer cell (arithmetic floor) and fraction.
    // ---------------------------------------------------------------
    logic signed [31:0]    x_c, z_c;
    logic [31:0]           cx_reg, cz_reg, cx1_reg, cz1_reg;
    logic [FRAC_BITS-1:0]  fx_reg, fz_reg;
    logic signed [D_W-1:0] dx0_c, dz0_c, dx1_c, dz1_c;

    assign x_c = s_tdata[31:0];
    assign z_c = s_tdata[63:32];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg  <= 32'(x_c >>> FRAC_BITS);
            cz_reg  <= 32'(z_c >>> FRAC_BITS);
            cx1_reg <= 32'(x_c >>> FRAC_BITS) + 32'd1;
            cz1_reg <= 32'(z_c >>> FRAC_BITS) + 32'd1;
            fx_reg  <= x_c[FRAC_BITS-1:0];
            fz_reg  <= z_c[FRAC_BITS-1:0];
        end
    end

    // offsets from near and far corners
    assign dx0_c = $signed({1'b0, fx_reg});
    assign dz0_c = $signed({1'b0, fz_reg});
    assign dx1_c = dx0_c - $signed(D_W'(1) << FRAC_BITS);
    assign dz1_c = dz0_c - $signed(D_W'(1) << FRAC_BITS);

    // ---------------------------------------------------------------
    // Four corner units, 14 stages each.
    // ---------------------------------------------------------------
    logic signed [pgn_pkg::DOT_W-1:0] n00, n10, n01, n11;

    pgn_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c00 (
        .clk(clk), .en(adv), .seed(noise_seed_reg),
        .cx(cx_reg), .cz(cz_reg), .dx(dx0_c), .dz(dz0_c), .dot(n00));

    pgn_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c10 (
        .clk(clk), .en(adv), .seed(noise_seed_reg),
        .cx(cx1_reg), .cz(cz_reg), .dx(dx1_c), .dz(dz0_c), .dot(n10));

    pgn_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c01 (
        .clk(clk), .en(adv), .seed(noise_seed_reg),
        .cx(cx_reg), .cz(cz1_reg), .dx(dx0_c), .dz(dz1_c), .dot(n01));

    pgn_corner #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_c11 (
        .clk(clk), .en(adv), .seed(noise_seed_reg),
        .cx(cx1_reg), .cz(cz1_reg), .dx(dx1_c), .dz(dz1_c), .dot(n11));

    // ---------------------------------------------------------------
    // Quintic fade 6t^5-15t^4+10t^3 in Q28, lane 0 = u (x), lane 1 = v (z).
    // Four stages, then a delay line to meet the corner outputs.
    // ---------------------------------------------------------------
    logic [FT_W-1:0]         ft_c [2];
    logic [FT_W-1:0]         ft_reg [2];
    logic [FT_W-1:0]         tt_reg [2];
    logic signed [A6_W-1:0]  a6_reg [2];
    logic [FT_W-1:0]         t3_reg [2][2];
    logic signed [Q_W-1:0]   q0_reg [2];
    logic signed [Q_W-1:0]   q_reg  [2];
    logic [W_W-1:0]          w_reg  [2][W_DLY+1];

    assign ft_c[0] = {fx_reg, (FT_W - FRAC_BITS)'(0)};
    assign ft_c[1] = {fz_reg, (FT_W - FRAC_BITS)'(0)};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 2; l++)
            begin
                ft_reg[l]    <= ft_c[l];
                tt_reg[l]    <= FT_W'((SQF_W'(ft_c[l]) * SQF_W'(ft_c[l])) >> 28);
                a6_reg[l]    <= $signed(A6_W'(ft_c[l]) * A6_W'(6))
                                - $signed(A6_W'(15) << 28);
                t3_reg[l][0] <= FT_W'((SQF_W'(tt_reg[l]) * SQF_W'(ft_reg[l])) >> 28);
                q0_reg[l]    <= Q_W'((QP_W'($signed({1'b0, ft_reg[l]}))
                                      * QP_W'(a6_reg[l])) >>> 28);
                t3_reg[l][1] <= t3_reg[l][0];
                q_reg[l]     <= q0_reg[l] + $signed(Q_W'(10) << 28);
                w_reg[l][0]  <= W_W'((WP_W'($signed({1'b0, t3_reg[l][1]}))
                                      * WP_W'(q_reg[l])) >>> 28);
                for (int k = 1; k <= W_DLY; k++)
                    w_reg[l][k] <= w_reg[l][k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Blend: x lerps on both rows, then z lerp, round, saturate.
    // ---------------------------------------------------------------
    logic signed [DIF_W-1:0]          d0_reg, d1_reg, e_reg;
    logic signed [pgn_pkg::DOT_W-1:0] n00_reg, n01_reg, n00b_reg, n01b_reg;
    logic signed [DIF_W-1:0]          pa_reg, pb_reg, pe_reg;
    logic signed [DIF_W-1:0]          la_reg, lb_reg, la2_reg;
    logic signed [DIF_W-1:0]          la3_reg, la_hold_c;
    logic signed [R_W-1:0]            r_reg;
    logic [W_W-1:0]                   u1_reg, v_reg [4];
    logic signed [R_W-1:0]            rr_c;
    logic [15:0]                      sat_c;

    always_comb
    begin
        rr_c = (r_reg + (R_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
        if (rr_c > $signed(R_W'(32767)))
            sat_c = 16'h7FFF;
        else if (rr_c < -$signed(R_W'(32768)))
            sat_c = 16'h8000;
        else
            sat_c = rr_c[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // B1
            d0_reg  <= DIF_W'(n10) - DIF_W'(n00);
            d1_reg  <= DIF_W'(n11) - DIF_W'(n01);
            n00_reg <= n00;
            n01_reg <= n01;
            u1_reg  <= w_reg[0][W_DLY];
            v_reg[0] <= w_reg[1][W_DLY];
            // B2
            pa_reg   <= DIF_W'((BP_W'($signed({1'b0, u1_reg})) * BP_W'(d0_reg)) >>> 28);
            pb_reg   <= DIF_W'((BP_W'($signed({1'b0, u1_reg})) * BP_W'(d1_reg)) >>> 28);
            n00b_reg <= n00_reg;
            n01b_reg <= n01_reg;
            v_reg[1] <= v_reg[0];
            // B3
            la_reg   <= DIF_W'(n00b_reg) + pa_reg;
            lb_reg   <= DIF_W'(n01b_reg) + pb_reg;
            v_reg[2] <= v_reg[1];
            // B4
            e_reg    <= lb_reg - la_reg;
            la2_reg  <= la_reg;
            v_reg[3] <= v_reg[2];
            // B5
            pe_reg   <= DIF_W'((BP_W'($signed({1'b0, v_reg[3]})) * BP_W'(e_reg)) >>> 28);
            // B6
            r_reg    <= R_W'(la_hold_c) + R_W'(pe_reg);
            // B7: output register
            m_tdata  <= sat_c;
        end
    end

    // la must line up with pe (one extra stage past B4)
    always_ff @(posedge clk)
    begin
        if (adv)
            la3_reg <= la2_reg;
    end
    assign la_hold_c = la3_reg;

`ifndef SYNTHESIS
    // a bubble in the stage before the output yields an empty output after an advance
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !vld_reg[LAT-2]) |=> !m_tvalid)
        else $error("output valid without a beat behind it");

    // a stall freezes the valid chain
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vld_reg[0]) && $stable(vld_reg[CORNER_OUT])))
        else $error("pipeline moved during stall");

    // fade weights stay in [0, 1]
    a_fade: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CORNER_OUT-1] |->
            (w_reg[0][W_DLY] <= (W_W'(1) << 28) && w_reg[1][W_DLY] <= (W_W'(1) << 28)))
        else $error("fade weight out of range");
`endif

endmodule

>>> tb/tb_perlin_gradient_noise_2d.sv
// Self-checking testbench for the 2D gradient noise pipeline.
`timescale 1ns / 1ps

module tb_perlin_gradient_noise_2d;

    localparam int FRAC_BITS     = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int LATENCY       = 22;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // x_coord [31:0], z_coord [63:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // noise_value [15:0]
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    int error_count = 0;

    // sender idle and receiver stall rates, percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, in cycles, served by the result-side process
    int hold_cycles    = 0;

    perlin_gradient_noise_2d #(
        .FRAC_BITS    (FRAC_BITS),
        .ANGLE_BITS   (ANGLE_BITS),
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Predicts noise values and keeps those still owed by the pipeline.
    class noise_scoreboard;
        logic [31:0]        seed;
        logic signed [15:0] pending_noise[$];

        function new();
            seed = '0;
        endfunction

        // arithmetic shift right, floor
        static function longint asr(longint v, int n);
            return v >>> n;
        endfunction

        function logic [15:0] hash16(logic [31:0] cx, logic [31:0] cz);
            logic [31:0] h;
            h = (cx * pgn_pkg::HASH_MUL_X) ^ (cz * pgn_pkg::HASH_MUL_Z) ^ seed;
            h = h * h * h * pgn_pkg::HASH_MUL_C;
            h = h ^ (h >> pgn_pkg::HASH_SHIFT);
            return h[15:0];
        endfunction

        static function longint qsine(int unsigned p);
            longint t, t2, acc, s;
            t   = longint'(p) << (32 - ANGLE_BITS);
            t2  = asr(t * t, 30);
            acc = 172272;
            acc = -5026995 + asr(acc * t2, 30);
            acc = 85569306 + asr(acc * t2, 30);
            acc = -693598668 + asr(acc * t2, 30);
            acc = 1686629713 + asr(acc * t2, 30);
            s   = asr(acc * t, 30);
            s   = asr(s + (longint'(1) << 14), 15);
            if (s < 0) s = 0;
            if (s > 32768) s = 32768;
            return s;
        endfunction

        static function longint fsine(int unsigned a);
            int unsigned qtr, p;
            qtr = 1 << (ANGLE_BITS - 2);
            p   = a & (qtr - 1);
            case ((a >> (ANGLE_BITS - 2)) & 3)
                0: return qsine(p);
                1: return qsine(qtr - p);
                2: return -qsine(p);
                default: return -qsine(qtr - p);
            endcase
        endfunction

        static function longint fade_w(int unsigned f);
            longint t, t3, q;
            t  = longint'(f) << (28 - FRAC_BITS);
            t3 = asr(asr(t * t, 28) * t, 28);
            q  = asr(t * (6 * t - (longint'(15) << 28)), 28) + (longint'(10) << 28);
            return asr(t3 * q, 28);
        endfunction

        function longint dot(logic [31:0] cx, logic [31:0] cz, longint dx, longint dz);
            int unsigned a, msk;
            longint gs, gc, n;
            int w;
            msk = (1 << ANGLE_BITS) - 1;
            a   = hash16(cx, cz) >> (16 - ANGLE_BITS);
            gs  = fsine(a);
            gc  = fsine((a + (1 << (ANGLE_BITS - 2))) & msk);
            n   = gc * dx + gs * dz;
            w   = 15 + FRAC_BITS;
            if (w >= 30)
                return asr(n, w - 30);
            return n * (longint'(1) << (30 - w));
        endfunction

        static function longint lerp(longint a, longint b, longint w);
            return a + asr(w * (b - a), 28);
        endfunction

        function void note_point(logic [31:0] x, logic [31:0] z);
            logic [31:0] cx, cz;
            longint fx, fz, one, u, v, r;
            cx  = $signed(x) >>> FRAC_BITS;
            cz  = $signed(z) >>> FRAC_BITS;
            fx  = x & ((32'd1 << FRAC_BITS) - 1);
            fz  = z & ((32'd1 << FRAC_BITS) - 1);
            one = longint'(1) << FRAC_BITS;
            u   = fade_w(fx);
            v   = fade_w(fz);
            r   = lerp(lerp(dot(cx, cz, fx, fz), dot(cx + 1, cz, fx - one, fz), u),
                       lerp(dot(cx, cz + 1, fx, fz - one),
                            dot(cx + 1, cz + 1, fx - one, fz - one), u), v);
            r = asr(r + (longint'(1) << (29 - OUT_FRAC_BITS)), 30 - OUT_FRAC_BITS);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            pending_noise.push_back(r[15:0]);
        endfunction

        task check_noise(logic [15:0] got);
            logic signed [15:0] want;
            if (pending_noise.size() == 0)
            begin
                report_mismatch($sformatf("unexpected noise beat %h", got));
                return;
            end
            want = pending_noise.pop_front();
            if (got !== want)
                report_mismatch($sformatf("noise_value got %h want %h", got, want));
        endtask
    endclass

    noise_scoreboard sb = new();

    // Result side: random stall plus an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_noise(m_tdata);
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready    <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one point, hold until taken; beat is logged when accepted.
    task automatic send_point(input logic [31:0] x, input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_point(x, z);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_noise.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Seed only changes with the pipeline empty.
    task automatic write_seed(input logic [31:0] s);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= s;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.seed = s;
    endtask

    // Small coordinates around a few cells, values near the range extremes, some full-range values.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000 * $urandom_range(8);
            2: return {$urandom_range(2) == 0 ? 16'h7FFF : 16'h8000, 16'($urandom)};
            default: return $signed(32'($urandom_range(20))) - 10 <<< 16 | 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) send_point(rand_coord(), rand_coord());
        drain();
    endtask

    initial
    begin
        logic [31:0] edge_vals[8];
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        edge_vals   = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'h0000_FFFF, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, cell+1 at top of range, saturation region
        foreach (edge_vals[i])
            send_point(edge_vals[i], edge_vals[(i + 3) % 8]);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h0000_8000, 32'h0000_8000);
        send_point(32'h5555_AAAA, 32'hAAAA_5555);
        drain();

        write_seed(32'h7FFF_FFFF);
        random_phase(300, 0, 0);
        write_seed(32'h8000_0000);
        random_phase(300, 77, 0);
        write_seed(32'hFFFF_FFFF);
        random_phase(300, 0, 77);
        write_seed($urandom);
        random_phase(300, 31, 31);

        // long hold-off while the sender keeps pushing, so the input stalls
        write_seed($urandom);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 200;
        repeat (150) send_point(rand_coord(), rand_coord());
        drain();

        // sender pauses until all owed results are in, repeatedly
        write_seed(32'h0);
        repeat (20)
        begin
            repeat (20) send_point(rand_coord(), rand_coord());
            drain();
        end
        write_seed($urandom);
        random_phase(250, 0, 0);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
rtl/pgn_pkg.sv
rtl/pgn_corner.sv
rtl/perlin_gradient_noise_2d.sv
tb/tb_perlin_gradient_noise_2d.sv
